// ===== rtl/core/bfd_pkg.sv =====
package bfd_pkg;

    localparam int DEPTH_DEF   = 1024;
    localparam int MAX_POP_DEF = 64;

    localparam int OP_W   = 2;
    localparam int DATA_W = 8;
    localparam int CNT_W  = 7;
    localparam int REF_W  = 16;
    localparam int DROP_W = 32;
    localparam int PEND_W = 10;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH    = 2'd0,
        OP_POP     = 2'd1,
        OP_REFUSED = 2'd2,
        OP_PORT    = 2'd3
    } t_op;

    // Decoded item as it travels from the front to the back
    typedef struct packed {
        t_op               op;
        logic [DATA_W-1:0] push_byte;
        logic              end_of_message;
        logic [CNT_W-1:0]  pop_count;
        logic [REF_W-1:0]  refused_length;
        logic              port_open_flag;
    } t_cmd;

endpackage

// ===== rtl/core/bfd_ram.sv =====
module bfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/bfd_front.sv =====
module bfd_front #(
    parameter int MAX_POP = bfd_pkg::MAX_POP_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [bfd_pkg::OP_W-1:0]    i_operation,
    input  logic [bfd_pkg::DATA_W-1:0]  i_push_byte,
    input  logic                        i_end_of_message,
    input  logic [bfd_pkg::CNT_W-1:0]   i_pop_count,
    input  logic [bfd_pkg::REF_W-1:0]   i_refused_length,
    input  logic                        i_port_open_flag,
    output logic                        o_cmd_valid,
    input  logic                        i_cmd_ready,
    output bfd_pkg::t_cmd               o_cmd
);
    import bfd_pkg::*;

    localparam logic [CNT_W-1:0] PopLimit = CNT_W'(MAX_POP);

    t_cmd       r_q [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_cnt, n_cnt;
    t_cmd       dec;
    logic       push_q, pop_q;

    // Classify: type the operation and clamp the pop count
    always_comb begin
        dec.op             = t_op'(i_operation);
        dec.push_byte      = i_push_byte;
        dec.end_of_message = i_end_of_message;
        dec.pop_count      = (i_pop_count > PopLimit) ? PopLimit : i_pop_count;
        dec.refused_length = i_refused_length;
        dec.port_open_flag = i_port_open_flag;
    end

    assign o_in_ready  = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rptr];

    assign push_q = i_in_valid && o_in_ready;
    assign pop_q  = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_wptr = push_q ? ~r_wptr : r_wptr;
        n_rptr = pop_q ? ~r_rptr : r_rptr;
        n_cnt  = r_cnt + 2'(push_q) - 2'(pop_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_q) begin
            r_q[r_wptr] <= dec;
        end
    end

endmodule

// ===== rtl/core/bfd_back.sv =====
module bfd_back #(
    parameter int DEPTH = bfd_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    output logic                        o_cmd_ready,
    input  bfd_pkg::t_cmd               i_cmd,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_byte_valid,
    output logic [bfd_pkg::DATA_W-1:0]  o_popped_byte,
    output logic                        o_last_result,
    output logic                        o_stored,
    output logic [bfd_pkg::PEND_W-1:0]  o_pending_bytes,
    output logic [bfd_pkg::DROP_W-1:0]  o_drop_total
);
    import bfd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = (AW > CNT_W) ? AW : CNT_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_POP  = 2'b10
    } t_state;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_wr_idx, n_wr_idx;
    logic [AW-1:0]       r_rd_idx, n_rd_idx;
    logic                r_open, n_open;
    logic                r_discard, n_discard;
    logic [DROP_W-1:0]   r_drop, n_drop;
    logic [CNT_W-1:0]    r_remain, n_remain;
    logic                r_out_valid, n_out_valid;
    logic                r_byte_valid;
    logic [DATA_W-1:0]   r_byte;
    logic                r_last;
    logic                r_stored;
    logic [PEND_W-1:0]   r_pending;

    logic                slot_free;
    logic                emit;
    logic                e_byte_valid, e_last, e_stored;
    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;
    logic [AW-1:0]       avail;
    logic [CW-1:0]       avail_ext, cnt_ext, pop_n;
    logic [CNT_W-1:0]    pop_n7;

    bfd_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_idx),
        .i_wdata (i_cmd.push_byte),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign slot_free = !r_out_valid || i_out_ready;
    assign avail     = r_wr_idx - r_rd_idx;
    assign avail_ext = CW'(avail);
    assign cnt_ext   = CW'(i_cmd.pop_count);
    assign pop_n     = (avail_ext < cnt_ext) ? avail_ext : cnt_ext;
    assign pop_n7    = CNT_W'(pop_n);

    always_comb begin
        n_state      = r_state;
        n_wr_idx     = r_wr_idx;
        n_rd_idx     = r_rd_idx;
        n_open       = r_open;
        n_discard    = r_discard;
        n_drop       = r_drop;
        n_remain     = r_remain;
        o_cmd_ready  = 1'b0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_raddr    = r_rd_idx;
        emit         = 1'b0;
        e_byte_valid = 1'b0;
        e_last       = 1'b1;
        e_stored     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.op == OP_POP && pop_n7 != '0) begin
                        // start the byte stream with a read of the head
                        o_cmd_ready = 1'b1;
                        ram_re      = 1'b1;
                        n_remain    = pop_n7;
                        n_state     = S_POP;
                    end else if (slot_free) begin
                        o_cmd_ready = 1'b1;
                        emit        = 1'b1;
                        unique case (i_cmd.op)
                            OP_PUSH: begin
                                if (!r_discard && (r_wr_idx + AW'(1)) != r_rd_idx) begin
                                    ram_we   = 1'b1;
                                    n_wr_idx = r_wr_idx + AW'(1);
                                    e_stored = 1'b1;
                                end else begin
                                    if (r_open) begin
                                        n_drop = r_drop + DROP_W'(1);
                                    end
                                    n_discard = !i_cmd.end_of_message;
                                end
                            end
                            OP_POP: begin
                                // nothing to return: a lone empty result
                            end
                            OP_REFUSED: begin
                                if (r_open) begin
                                    n_drop = r_drop + DROP_W'(i_cmd.refused_length);
                                end
                            end
                            OP_PORT: begin
                                n_open = i_cmd.port_open_flag;
                                if (i_cmd.port_open_flag) begin
                                    n_wr_idx = '0;
                                    n_rd_idx = '0;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            S_POP: begin
                if (slot_free) begin
                    emit         = 1'b1;
                    e_byte_valid = 1'b1;
                    n_rd_idx     = r_rd_idx + AW'(1);
                    n_remain     = r_remain - CNT_W'(1);
                    e_last       = (r_remain == CNT_W'(1));
                    if (e_last) begin
                        n_state = S_IDLE;
                    end else begin
                        // fetch the next byte while this one leaves
                        ram_re    = 1'b1;
                        ram_raddr = r_rd_idx + AW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = emit || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_open      <= 1'b0;
            r_discard   <= 1'b0;
            r_drop      <= '0;
            r_remain    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_idx    <= n_wr_idx;
            r_rd_idx    <= n_rd_idx;
            r_open      <= n_open;
            r_discard   <= n_discard;
            r_drop      <= n_drop;
            r_remain    <= n_remain;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte_valid <= e_byte_valid;
            r_byte       <= e_byte_valid ? ram_rdata : '0;
            r_last       <= e_last;
            r_stored     <= e_stored;
            r_pending    <= PEND_W'(n_wr_idx - n_rd_idx);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_byte_valid    = r_byte_valid;
    assign o_popped_byte   = r_byte;
    assign o_last_result   = r_last;
    assign o_stored        = r_stored;
    assign o_pending_bytes = r_pending;
    assign o_drop_total    = r_drop;

    a_pop_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_POP |-> r_remain != '0)
        else $error("pop in progress with no bytes left");

    a_no_take_in_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_POP |-> !o_cmd_ready)
        else $error("item taken while a pop is streaming");

    a_plain_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_byte_valid |-> r_last)
        else $error("result without a byte must close its item");

    a_byte_not_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_byte_valid |-> !r_stored)
        else $error("popped byte flagged as stored");

    a_drop_only_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !emit |=> $stable(r_drop))
        else $error("drop counter moved without a result");

endmodule

// ===== rtl/core/byte_fifo_with_drop_count_unit.sv =====
// Byte FIFO with drop accounting.
// Input channel (i_in_valid / o_in_ready) takes one item per handshake: push a
// byte, pop up to i_pop_count bytes, note a refused length, or a port event.
// Output channel (o_out_valid / i_out_ready) returns result items: one for a
// push, a refused-length note, a port event or an empty pop; one per byte
// for a pop that finds data, the final one marked by o_last_result.
// A two-entry item queue sits between the accepting front and the executing
// back, so the input keeps taking items while a result waits in the output
// register.
// A non-pop item's result is registered and shows in the cycle after the back
// takes it. A pop first reads the head of the ring, then streams one byte per
// cycle while the output register is free; the ring store has a single read port.
// Reset empties the ring, closes the port and clears the drop counter; the
// ring contents are left as they are and never read before being written.
// When the receiver stalls, the output register holds its item, the back
// waits and the item queue fills, after which o_in_ready drops.
module byte_fifo_with_drop_count_unit #(
    parameter int DEPTH   = bfd_pkg::DEPTH_DEF,
    parameter int MAX_POP = bfd_pkg::MAX_POP_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [bfd_pkg::OP_W-1:0]    i_operation,
    input  logic [bfd_pkg::DATA_W-1:0]  i_push_byte,
    input  logic                        i_end_of_message,
    input  logic [bfd_pkg::CNT_W-1:0]   i_pop_count,
    input  logic [bfd_pkg::REF_W-1:0]   i_refused_length,
    input  logic                        i_port_open_flag,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_byte_valid,
    output logic [bfd_pkg::DATA_W-1:0]  o_popped_byte,
    output logic                        o_last_result,
    output logic                        o_stored,
    output logic [bfd_pkg::PEND_W-1:0]  o_pending_bytes,
    output logic [bfd_pkg::DROP_W-1:0]  o_drop_total
);
    import bfd_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    t_cmd cmd;

    bfd_front #(
        .MAX_POP (MAX_POP)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_push_byte      (i_push_byte),
        .i_end_of_message (i_end_of_message),
        .i_pop_count      (i_pop_count),
        .i_refused_length (i_refused_length),
        .i_port_open_flag (i_port_open_flag),
        .o_cmd_valid      (cmd_valid),
        .i_cmd_ready      (cmd_ready),
        .o_cmd            (cmd)
    );

    bfd_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (cmd_valid),
        .o_cmd_ready     (cmd_ready),
        .i_cmd           (cmd),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_byte_valid    (o_byte_valid),
        .o_popped_byte   (o_popped_byte),
        .o_last_result   (o_last_result),
        .o_stored        (o_stored),
        .o_pending_bytes (o_pending_bytes),
        .o_drop_total    (o_drop_total)
    );

endmodule
